FILE: rtl/core/gbed_pkg.sv
// ---------------------------------------------------------------------------
// gbed_pkg
// Shared types, register map and helpers of the GPIO bank with event detect.
// ---------------------------------------------------------------------------
package gbed_pkg;

    localparam int PIN_COUNT   = 54;
    localparam int FSEL_WORDS  = 6;
    localparam int FSEL_PINS   = 10;
    localparam int FSEL_BITS   = 30;
    localparam int DRIVE_PINS  = (PIN_COUNT < FSEL_WORDS * FSEL_PINS) ?
                                 PIN_COUNT : FSEL_WORDS * FSEL_PINS;
    localparam int EN_COUNT    = 6;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 32;

    // enable register order in the map
    localparam int EN_RISE       = 0;
    localparam int EN_FALL       = 1;
    localparam int EN_HIGH       = 2;
    localparam int EN_LOW        = 3;
    localparam int EN_ASYNC_RISE = 4;
    localparam int EN_ASYNC_FALL = 5;

    // word addresses (low half; high half is the next word)
    localparam logic [ADDR_W-1:0] ADDR_SET_LO   = 6'd7;
    localparam logic [ADDR_W-1:0] ADDR_SET_HI   = 6'd8;
    localparam logic [ADDR_W-1:0] ADDR_CLR_LO   = 6'd10;
    localparam logic [ADDR_W-1:0] ADDR_CLR_HI   = 6'd11;
    localparam logic [ADDR_W-1:0] ADDR_LEV_LO   = 6'd13;
    localparam logic [ADDR_W-1:0] ADDR_LEV_HI   = 6'd14;
    localparam logic [ADDR_W-1:0] ADDR_EVT_LO   = 6'd16;
    localparam logic [ADDR_W-1:0] ADDR_EVT_HI   = 6'd17;
    localparam int                ADDR_EN_BASE  = 19;
    localparam int                ADDR_EN_STEP  = 3;

    localparam logic [2:0] FSEL_OUTPUT = 3'd1;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_TICK
    } op_t;

    typedef logic [PIN_COUNT-1:0]             pins_t;
    typedef logic [FSEL_BITS-1:0]             fsel_word_t;
    typedef fsel_word_t [FSEL_WORDS-1:0]      fsel_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        pins_t             out_levels;
        pins_t             out_enable;
        logic              irq;
    } res_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
        logic       hi;
    } en_dec_t;

    // place a 32-bit word on the low or high half of the pin vector
    function automatic pins_t half_spread(logic hi, logic [DATA_W-1:0] v);
        logic [63:0] w;
        w = hi ? {v, 32'b0} : {32'b0, v};
        return w[PIN_COUNT-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] half_get(pins_t r, logic hi);
        logic [63:0] w;
        w = 64'(r);
        return hi ? w[63:32] : w[31:0];
    endfunction

    function automatic pins_t half_put(pins_t r, logic hi, logic [DATA_W-1:0] v);
        return (r & ~half_spread(hi, '1)) | half_spread(hi, v);
    endfunction

    // function select bits that exist in word w
    function automatic fsel_word_t fsel_mask(int unsigned w);
        fsel_word_t m;
        m = '0;
        for (int i = 0; i < FSEL_PINS; i++)
        begin
            if (w * FSEL_PINS + i < PIN_COUNT)
                m[i*3 +: 3] = 3'b111;
        end
        return m;
    endfunction

    function automatic en_dec_t en_decode(logic [ADDR_W-1:0] a);
        en_dec_t d;
        d = '0;
        for (int k = 0; k < EN_COUNT; k++)
        begin
            if (a == ADDR_W'(ADDR_EN_BASE + ADDR_EN_STEP * k))
            begin
                d.hit = 1'b1;
                d.idx = 3'(k);
                d.hi  = 1'b0;
            end
            if (a == ADDR_W'(ADDR_EN_BASE + ADDR_EN_STEP * k + 1))
            begin
                d.hit = 1'b1;
                d.idx = 3'(k);
                d.hi  = 1'b1;
            end
        end
        return d;
    endfunction

    function automatic pins_t drive_mask(fsel_t f);
        pins_t m;
        m = '0;
        for (int p = 0; p < DRIVE_PINS; p++)
            m[p] = (f[p / FSEL_PINS][(p % FSEL_PINS) * 3 +: 3] == FSEL_OUTPUT);
        return m;
    endfunction

endpackage

FILE: rtl/core/gbed_core.sv
// ---------------------------------------------------------------------------
// gbed_core
// Register file, write/clear logic and event detection for one request.
// ---------------------------------------------------------------------------
module gbed_core
    import gbed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [1:0]        op,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    input  pins_t             pin_levels,
    output res_t              res
);

    fsel_t fsel_reg, fsel_next;
    pins_t latch_reg, latch_next;
    pins_t sample_reg, sample_next;
    pins_t flags_reg, flags_next;
    pins_t en_reg  [EN_COUNT];
    pins_t en_next [EN_COUNT];

    en_dec_t          dec;
    logic [DATA_W-1:0] rd;
    pins_t            rise;
    pins_t            fall;
    pins_t            hits;

    always_comb
    begin
        dec         = en_decode(address);
        fsel_next   = fsel_reg;
        latch_next  = latch_reg;
        sample_next = sample_reg;
        flags_next  = flags_reg;
        for (int k = 0; k < EN_COUNT; k++)
            en_next[k] = en_reg[k];
        rd   = '0;
        rise = ~sample_reg & pin_levels;
        fall = sample_reg & ~pin_levels;
        hits = (rise & (en_reg[EN_RISE] | en_reg[EN_ASYNC_RISE]))
             | (fall & (en_reg[EN_FALL] | en_reg[EN_ASYNC_FALL]))
             | (pin_levels & en_reg[EN_HIGH])
             | (~pin_levels & en_reg[EN_LOW]);

        unique case (op)
            OP_READ:
            begin
                if (address < ADDR_W'(FSEL_WORDS))
                    rd = DATA_W'(fsel_reg[address[2:0]]);
                else if (address == ADDR_LEV_LO || address == ADDR_LEV_HI)
                    rd = half_get(sample_reg, address == ADDR_LEV_HI);
                else if (address == ADDR_EVT_LO || address == ADDR_EVT_HI)
                    rd = half_get(flags_reg, address == ADDR_EVT_HI);
                else if (dec.hit)
                    rd = half_get(en_reg[dec.idx], dec.hi);
            end
            OP_WRITE:
            begin
                for (int k = 0; k < FSEL_WORDS; k++)
                begin
                    if (address == ADDR_W'(k))
                        fsel_next[k] = write_data[FSEL_BITS-1:0] & fsel_mask(k);
                end
                if (address == ADDR_SET_LO || address == ADDR_SET_HI)
                    latch_next = latch_reg
                               | half_spread(address == ADDR_SET_HI, write_data);
                else if (address == ADDR_CLR_LO || address == ADDR_CLR_HI)
                    latch_next = latch_reg
                               & ~half_spread(address == ADDR_CLR_HI, write_data);
                else if (address == ADDR_EVT_LO || address == ADDR_EVT_HI)
                    flags_next = flags_reg
                               & ~half_spread(address == ADDR_EVT_HI, write_data);
                else if (dec.hit)
                    en_next[dec.idx] = half_put(en_reg[dec.idx], dec.hi, write_data);
            end
            OP_TICK:
            begin
                flags_next  = flags_reg | hits;
                sample_next = pin_levels;
            end
            default:
            begin
                // spare opcode: no effect
            end
        endcase

        res.read_data  = rd;
        res.out_levels = latch_next;
        res.out_enable = drive_mask(fsel_next);
        res.irq        = |flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsel_reg   <= '0;
            latch_reg  <= '0;
            sample_reg <= '0;
            flags_reg  <= '0;
            for (int k = 0; k < EN_COUNT; k++)
                en_reg[k] <= '0;
        end
        else if (step)
        begin
            fsel_reg   <= fsel_next;
            latch_reg  <= latch_next;
            sample_reg <= sample_next;
            flags_reg  <= flags_next;
            for (int k = 0; k < EN_COUNT; k++)
                en_reg[k] <= en_next[k];
        end
    end

endmodule

FILE: rtl/core/gpio_bank_with_event_detect.sv
// ---------------------------------------------------------------------------
// gpio_bank_with_event_detect
// Register-mapped GPIO bank with output latch and sticky pin event flags.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | op, address, write_data, pin_levels
//  out     | out_valid / out_ready| read_data, out_levels, out_enable, irq
//
//  One request per cycle sustained while the result side is ready; a request
//  passes the input register, then the register file logic into the result register.
//  The register file updates as a request moves into the result register.
//  A stalled result holds; the input register still refills behind it.
//  Reset clears the valid flags and every core register, so all pins start as inputs.
// ---------------------------------------------------------------------------
module gpio_bank_with_event_detect
    import gbed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    input  pins_t             pin_levels,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] read_data,
    output pins_t             out_levels,
    output pins_t             out_enable,
    output logic              irq
);

    logic              ivalid_reg;
    logic [1:0]        op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;
    pins_t             levels_reg;
    logic              ovalid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic              advance;

    assign advance  = ivalid_reg && (!ovalid_reg || out_ready);
    assign in_ready = !ivalid_reg || advance;

    gbed_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .op         (op_reg),
        .address    (addr_reg),
        .write_data (wdata_reg),
        .pin_levels (levels_reg),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                ivalid_reg <= 1'b1;
            else if (advance)
                ivalid_reg <= 1'b0;

            if (advance)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg     <= op;
            addr_reg   <= address;
            wdata_reg  <= write_data;
            levels_reg <= pin_levels;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid  = ovalid_reg;
    assign read_data  = res_reg.read_data;
    assign out_levels = res_reg.out_levels;
    assign out_enable = res_reg.out_enable;
    assign irq        = res_reg.irq;

endmodule

FILE: sim/gpio_bank_with_event_detect_test.sv
// ---------------------------------------------------------------------------
// gpio_bank_with_event_detect_test
// Drives bus reads, bus writes, pin-sample ticks and spare opcodes into the
// GPIO bank, with bursty requests and a stalling result side. Every result is
// compared with a local model of the register file, output latch and sticky event flags.
// ---------------------------------------------------------------------------
module gpio_bank_with_event_detect_test;
    import gbed_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]        OP_NONE         = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_FSEL_FIRST = 6'd0;
    localparam logic [ADDR_W-1:0] ADDR_FSEL_LAST  = 6'd5;
    localparam logic [ADDR_W-1:0] ADDR_RISE_LO    = ADDR_W'(ADDR_EN_BASE + ADDR_EN_STEP * EN_RISE);
    localparam logic [ADDR_W-1:0] ADDR_LOW_HI     = ADDR_W'(ADDR_EN_BASE + ADDR_EN_STEP * EN_LOW + 1);
    localparam logic [ADDR_W-1:0] ADDR_PULL_FIRST = 6'd37;
    localparam logic [ADDR_W-1:0] ADDR_MAP_TOP    = 6'd63;
    localparam pins_t             PINS_NONE       = '0;
    localparam pins_t             PINS_ALL        = '1;
    localparam int                RANDOM_ITEMS    = 1200;
    localparam int                SETTLE_CYCLES   = 16;
    localparam int                CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        pins_t             levels;
        logic              known;
        logic [DATA_W-1:0] word;
    } gpio_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    pins_t             pin_levels;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] read_data;
    pins_t             out_levels;
    pins_t             out_enable;
    logic              irq;

    // model state, cleared to match reset
    logic [FSEL_BITS-1:0] fsel_words [FSEL_WORDS] = '{default: '0};
    pins_t                enables [EN_COUNT] = '{default: '0};
    pins_t                latch_bits  = '0;
    pins_t                sample_bits = '0;
    pins_t                event_bits  = '0;

    res_t      results_due [$];
    gpio_row_t script [$];
    pins_t     recent_levels = '0;
    int        mismatches = 0;
    int        cycle_count = 0;

    gpio_bank_with_event_detect u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .address    (address),
        .write_data (write_data),
        .pin_levels (pin_levels),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .out_levels (out_levels),
        .out_enable (out_enable),
        .irq        (irq)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic pins_t word_pins(logic upper, logic [DATA_W-1:0] v);
        logic [63:0] wide;
        wide = upper ? {v, 32'h0} : {32'h0, v};
        return wide[PIN_COUNT-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pins_word(pins_t r, logic upper);
        logic [63:0] wide;
        wide = {{(64 - PIN_COUNT){1'b0}}, r};
        return upper ? wide[63:32] : wide[31:0];
    endfunction

    // applies one request to the model and returns the result it should give
    function automatic res_t predict_gpio_step(logic [1:0] kind, logic [ADDR_W-1:0] a,
                                               logic [DATA_W-1:0] wd, pins_t lv);
        res_t                 r;
        int                   ai;
        int                   en_off;
        logic                 en_hit;
        int                   en_idx;
        logic                 en_upper;
        logic [FSEL_BITS-1:0] fmask;
        pins_t                rise;
        pins_t                fall;
        r = '0;
        ai = int'(a);
        en_off = ai - ADDR_EN_BASE;
        en_hit = en_off >= 0 && en_off < ADDR_EN_STEP * EN_COUNT &&
                 en_off % ADDR_EN_STEP != 2;
        en_idx = en_hit ? en_off / ADDR_EN_STEP : 0;
        en_upper = en_hit && en_off % ADDR_EN_STEP == 1;
        case (kind)
            OP_READ:
            begin
                if (ai < FSEL_WORDS)
                    r.read_data = DATA_W'(fsel_words[ai]);
                else if (a == ADDR_LEV_LO || a == ADDR_LEV_HI)
                    r.read_data = pins_word(sample_bits, a == ADDR_LEV_HI);
                else if (a == ADDR_EVT_LO || a == ADDR_EVT_HI)
                    r.read_data = pins_word(event_bits, a == ADDR_EVT_HI);
                else if (en_hit)
                    r.read_data = pins_word(enables[en_idx], en_upper);
            end
            OP_WRITE:
            begin
                if (ai < FSEL_WORDS)
                begin
                    fmask = '0;
                    for (int i = 0; i < FSEL_PINS; i++)
                        if (ai * FSEL_PINS + i < PIN_COUNT)
                            fmask[i*3 +: 3] = 3'b111;
                    fsel_words[ai] = wd[FSEL_BITS-1:0] & fmask;
                end
                else if (a == ADDR_SET_LO || a == ADDR_SET_HI)
                    latch_bits |= word_pins(a == ADDR_SET_HI, wd);
                else if (a == ADDR_CLR_LO || a == ADDR_CLR_HI)
                    latch_bits &= ~word_pins(a == ADDR_CLR_HI, wd);
                else if (a == ADDR_EVT_LO || a == ADDR_EVT_HI)
                    event_bits &= ~word_pins(a == ADDR_EVT_HI, wd);
                else if (en_hit)
                    enables[en_idx] = (enables[en_idx] & ~word_pins(en_upper, '1)) |
                                      word_pins(en_upper, wd);
            end
            OP_TICK:
            begin
                rise = ~sample_bits & lv;
                fall = sample_bits & ~lv;
                event_bits |= (rise & (enables[EN_RISE] | enables[EN_ASYNC_RISE])) |
                              (fall & (enables[EN_FALL] | enables[EN_ASYNC_FALL])) |
                              (lv & enables[EN_HIGH]) | (~lv & enables[EN_LOW]);
                sample_bits = lv;
            end
            default: ;
        endcase
        r.out_levels = latch_bits;
        for (int p = 0; p < PIN_COUNT && p < FSEL_WORDS * FSEL_PINS; p++)
            r.out_enable[p] = fsel_words[p / FSEL_PINS][(p % FSEL_PINS)*3 +: 3] == FSEL_OUTPUT;
        r.irq = |event_bits;
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(logic [1:0] kind, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] wd,
                         pins_t lv, logic known, logic [DATA_W-1:0] word);
        res_t want;
        in_valid   <= 1'b1;
        op         <= kind;
        address    <= a;
        write_data <= wd;
        pin_levels <= lv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = predict_gpio_step(kind, a, wd, lv);
        if (known)
            want.read_data = word;
        results_due.push_back(want);
        @(negedge clk);
    endtask

    // hold requests off until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due.size() != 0);
    endtask

    task automatic random_request(output logic [1:0] kind, output logic [ADDR_W-1:0] a,
                                  output logic [DATA_W-1:0] wd, output pins_t lv);
        int          pick;
        logic [63:0] wide;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            kind = OP_READ;
        else if (pick < 65)
            kind = OP_WRITE;
        else if (pick < 95)
            kind = OP_TICK;
        else
            kind = OP_NONE;
        a = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom_range(0, 63))
                                        : ADDR_W'($urandom_range(0, 39));
        case ($urandom_range(0, 7))
            0: wd = '0;
            1: wd = '1;
            2: wd = 32'h1 << $urandom_range(0, 31);
            3: wd = $urandom & $urandom & $urandom;
            default: wd = $urandom;
        endcase
        // function select words lean towards the drive code
        if (a < FSEL_WORDS && $urandom_range(0, 1) == 0)
        begin
            wd = {2'($urandom_range(0, 3)), 30'h0};
            for (int i = 0; i < FSEL_PINS; i++)
                wd[i*3 +: 3] = ($urandom_range(0, 1) == 0) ? FSEL_OUTPUT
                                                           : 3'($urandom_range(0, 7));
        end
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: lv = PINS_NONE;
            1: lv = PINS_ALL;
            2, 3: lv = recent_levels ^ (pins_t'(1) << $urandom_range(0, PIN_COUNT - 1))
                                     ^ (pins_t'(1) << $urandom_range(0, PIN_COUNT - 1));
            default: lv = wide[PIN_COUNT-1:0];
        endcase
        if (kind == OP_TICK)
            recent_levels = lv;
    endtask

    // result side stalls in runs of differing character
    initial
    begin
        int         mode;
        int         span;
        logic [7:0] pattern;
        out_ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            pattern = 8'($urandom) | 8'h01;
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 3) != 0;
                    2:
                    begin
                        out_ready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                    default: out_ready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    task automatic log_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request outstanding: data %h", read_data);
            end
            else
            begin
                want = results_due.pop_front();
                if (read_data !== want.read_data)
                    log_mismatch("read_data", 64'(want.read_data), 64'(read_data));
                if (out_levels !== want.out_levels)
                    log_mismatch("out_levels", 64'(want.out_levels), 64'(out_levels));
                if (out_enable !== want.out_enable)
                    log_mismatch("out_enable", 64'(want.out_enable), 64'(out_enable));
                if (irq !== want.irq)
                    log_mismatch("irq", 64'(want.irq), 64'(irq));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]        kind;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] wd;
        pins_t             lv;
        int                sent;
        int                burst;
        int                gap;
        bit                mid_drain_done;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_READ;
        address    = '0;
        write_data = '0;
        pin_levels = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, function select extremes, latch, rise and low enable paths
        script.push_back('{OP_READ,  ADDR_FSEL_FIRST, 32'h0,         PINS_NONE, 1'b1, 32'h0});
        script.push_back('{OP_READ,  ADDR_LEV_LO,     32'h0,         PINS_NONE, 1'b1, 32'h0});
        script.push_back('{OP_WRITE, ADDR_FSEL_FIRST, 32'hFFFF_FFFF, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_READ,  ADDR_FSEL_FIRST, 32'h0,         PINS_NONE, 1'b1, 32'h3FFF_FFFF});
        script.push_back('{OP_WRITE, ADDR_FSEL_LAST,  32'hFFFF_FFFF, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_READ,  ADDR_FSEL_LAST,  32'h0,         PINS_NONE, 1'b1, 32'h0000_0FFF});
        script.push_back('{OP_WRITE, ADDR_FSEL_FIRST, 32'h0924_9249, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_WRITE, ADDR_FSEL_LAST,  32'h0924_9249, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_WRITE, ADDR_SET_LO,     32'hFFFF_FFFF, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_WRITE, ADDR_SET_HI,     32'hFFFF_FFFF, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_READ,  ADDR_SET_LO,     32'h0,         PINS_NONE, 1'b1, 32'h0});
        script.push_back('{OP_WRITE, ADDR_CLR_HI,     32'hFFFF_FFFF, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_WRITE, ADDR_RISE_LO,    32'hFFFF_FFFF, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_WRITE, ADDR_LOW_HI,     32'hFFFF_FFFF, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_TICK,  ADDR_FSEL_FIRST, 32'h0,         PINS_ALL,  1'b0, 32'h0});
        script.push_back('{OP_READ,  ADDR_EVT_LO,     32'h0,         PINS_NONE, 1'b1, 32'hFFFF_FFFF});
        script.push_back('{OP_READ,  ADDR_LEV_HI,     32'h0,         PINS_NONE, 1'b1, 32'h003F_FFFF});
        script.push_back('{OP_TICK,  ADDR_FSEL_FIRST, 32'h0,         PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_READ,  ADDR_EVT_HI,     32'h0,         PINS_NONE, 1'b1, 32'h003F_FFFF});
        script.push_back('{OP_WRITE, ADDR_EVT_LO,     32'hFFFF_FFFF, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_WRITE, ADDR_EVT_HI,     32'hFFFF_FFFF, PINS_NONE, 1'b0, 32'h0});
        script.push_back('{OP_READ,  ADDR_PULL_FIRST, 32'h0,         PINS_NONE, 1'b1, 32'h0});
        script.push_back('{OP_READ,  ADDR_MAP_TOP,    32'h0,         PINS_NONE, 1'b1, 32'h0});
        script.push_back('{OP_NONE,  ADDR_EVT_LO,     32'h0,         PINS_NONE, 1'b1, 32'h0});
        script.push_back('{OP_READ,  ADDR_RISE_LO,    32'h0,         PINS_NONE, 1'b1, 32'hFFFF_FFFF});

        foreach (script[i])
            issue(script[i].kind, script[i].addr, script[i].data, script[i].levels,
                  script[i].known, script[i].word);
        drain_results();

        sent = 0;
        mid_drain_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                random_request(kind, a, wd, lv);
                issue(kind, a, wd, lv, 1'b0, 32'h0);
                sent++;
            end
            if (!mid_drain_done && sent >= RANDOM_ITEMS / 2)
            begin
                drain_results();
                mid_drain_done = 1'b1;
            end
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap)
                        @(negedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
